// ===== rtl/cbl_pkg.sv =====
`default_nettype none

package cbl_pkg;

  localparam int HISTORY_DEPTH_DEF = 8;

  localparam int CAP_W     = 8;
  localparam int VIB_W     = 7;
  localparam int TIMER_W   = 16;
  localparam int STEP_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Register map of the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_THRESHOLD  = 3'd0,
    REG_HIGH_THRESHOLD = 3'd1,
    REG_TICK_STEP_MS   = 3'd2,
    REG_STARTUP_ON_MS  = 3'd3,
    REG_SLOW_BLINK_MS  = 3'd4,
    REG_FAST_BLINK_MS  = 3'd5
  } cfg_reg_t;

  localparam logic [CAP_W-1:0]   LOW_THRESHOLD_RST  = 8'd50;
  localparam logic [CAP_W-1:0]   HIGH_THRESHOLD_RST = 8'd75;
  localparam logic [STEP_W-1:0]  TICK_STEP_MS_RST   = 8'd10;
  localparam logic [TIMER_W-1:0] STARTUP_ON_MS_RST  = 16'd3000;
  localparam logic [TIMER_W-1:0] SLOW_BLINK_MS_RST  = 16'd500;
  localparam logic [TIMER_W-1:0] FAST_BLINK_MS_RST  = 16'd60;

  localparam logic [VIB_W-1:0] VIB_STRONG = 7'd90;
  localparam logic [VIB_W-1:0] VIB_NONE   = 7'd0;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_SAMPLE  = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    BAND_NONE = 2'd0,
    BAND_HIGH = 2'd1,
    BAND_LOW  = 2'd2,
    BAND_MID  = 2'd3
  } band_t;

  typedef enum logic [5:0] {
    LED_IDLE        = 6'b000001,
    LED_SET_OFF     = 6'b000010,
    LED_SET_ON      = 6'b000100,
    LED_TIMED_START = 6'b001000,
    LED_TIMED_WAIT  = 6'b010000,
    LED_BLINK       = 6'b100000
  } led_mode_t;

endpackage

`default_nettype wire

// ===== rtl/charge_band_led_controller.sv =====
`default_nettype none

// Path: an accepted beat passes through the input register, then the result register.
// Throughput: one beat per cycle; the input register advances whenever the result register is
//   empty or being taken, and a result held by the receiver stalls the input once the input
//   register also holds a beat.
// Reset (rst, synchronous, active high): thresholds and timings return to their defaults,
//   history clears to zero and is marked unfilled, charger enabled, LED off in timed-on mode.
module charge_band_led_controller
  import cbl_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [7:0] capacity
  input  wire logic [2:0]           s_axis_tuser,   // [1:0] kind, [2] sample_ok
  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [31:0]               m_axis_tdata,   // [0] led_level, [1] charge_enable,
                                                    // [8:2] vibrate_strength,
                                                    // [16:9] newest_capacity,
                                                    // [24:17] oldest_capacity, [31:25] zero
  output logic [1:0]                m_axis_tuser,   // [1:0] band
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers; writes are taken in every cycle.
  // ---------------------------------------------------------------------------
  logic [CAP_W-1:0]   low_threshold;
  logic [CAP_W-1:0]   high_threshold;
  logic [STEP_W-1:0]  tick_step_ms;
  logic [TIMER_W-1:0] startup_on_ms;
  logic [TIMER_W-1:0] slow_blink_ms;
  logic [TIMER_W-1:0] fast_blink_ms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold  <= LOW_THRESHOLD_RST;
      high_threshold <= HIGH_THRESHOLD_RST;
      tick_step_ms   <= TICK_STEP_MS_RST;
      startup_on_ms  <= STARTUP_ON_MS_RST;
      slow_blink_ms  <= SLOW_BLINK_MS_RST;
      fast_blink_ms  <= FAST_BLINK_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LOW_THRESHOLD:  low_threshold  <= cfg_data[CAP_W-1:0];
        REG_HIGH_THRESHOLD: high_threshold <= cfg_data[CAP_W-1:0];
        REG_TICK_STEP_MS:   tick_step_ms   <= cfg_data[STEP_W-1:0];
        REG_STARTUP_ON_MS:  startup_on_ms  <= cfg_data;
        REG_SLOW_BLINK_MS:  slow_blink_ms  <= cfg_data;
        REG_FAST_BLINK_MS:  fast_blink_ms  <= cfg_data;
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. It advances into the result stage whenever that stage is
  // empty or its beat is being taken this cycle.
  // ---------------------------------------------------------------------------
  logic             in_valid;
  kind_t            in_kind;
  logic             in_ok;
  logic [CAP_W-1:0] in_cap;
  logic             advance;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind <= kind_t'(s_axis_tuser[1:0]);
      in_ok   <= s_axis_tuser[2];
      in_cap  <= s_axis_tdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Block state
  // ---------------------------------------------------------------------------
  logic [CAP_W-1:0]   history [HISTORY_DEPTH];
  logic               history_ready;
  logic               charging;
  led_mode_t          led_mode;
  logic [TIMER_W-1:0] led_elapsed;
  logic [TIMER_W-1:0] led_period;
  logic               led_pin;

  logic               history_ready_next;
  logic               charging_next;
  led_mode_t          led_mode_next;
  logic [TIMER_W-1:0] led_elapsed_next;
  logic [TIMER_W-1:0] led_period_next;
  logic               led_pin_next;
  band_t              band_next;
  logic [VIB_W-1:0]   vib_next;
  logic               fill_all;   // first sample after reset or restart loads every entry
  logic               shift_in;   // later sample that differs from the newest entry

  logic [TIMER_W-1:0] elapsed_sum;
  logic               period_done;

  // timer add wraps at 16 bits
  assign elapsed_sum = led_elapsed + TIMER_W'(tick_step_ms);
  assign period_done = (elapsed_sum >= led_period);

  always_comb begin
    history_ready_next = history_ready;
    charging_next      = charging;
    led_mode_next      = led_mode;
    led_elapsed_next   = led_elapsed;
    led_period_next    = led_period;
    led_pin_next       = led_pin;
    band_next          = BAND_NONE;
    vib_next           = VIB_NONE;
    fill_all           = 1'b0;
    shift_in           = 1'b0;

    unique case (in_kind)
      KIND_TICK: begin
        unique case (led_mode)
          LED_SET_OFF: begin
            led_pin_next  = 1'b0;
            led_mode_next = LED_IDLE;
          end
          LED_SET_ON: begin
            led_pin_next  = 1'b1;
            led_mode_next = LED_IDLE;
          end
          LED_TIMED_START: begin
            led_pin_next     = 1'b1;
            led_elapsed_next = '0;
            led_period_next  = startup_on_ms;
            led_mode_next    = LED_TIMED_WAIT;
          end
          LED_TIMED_WAIT: begin
            led_elapsed_next = elapsed_sum;
            if (period_done) begin
              led_pin_next  = 1'b0;
              led_mode_next = LED_IDLE;
            end
          end
          LED_BLINK: begin
            // toggle once the half-period is used up, then restart the count
            led_elapsed_next = period_done ? '0 : elapsed_sum;
            if (period_done) begin
              led_pin_next = !led_pin;
            end
          end
          default: ; // idle: hold the pin
        endcase
      end
      KIND_SAMPLE: begin
        if (in_ok) begin
          history_ready_next = 1'b1;
          fill_all           = !history_ready;
          shift_in           = history_ready && (history[0] != in_cap);
          // after the update the newest entry always equals the sample
          if (in_cap > high_threshold) begin
            charging_next   = 1'b0;
            led_mode_next   = LED_BLINK;
            led_period_next = slow_blink_ms;
            band_next       = BAND_HIGH;
            vib_next        = VIB_STRONG;
          end else if (in_cap < low_threshold) begin
            charging_next   = 1'b1;
            led_mode_next   = LED_BLINK;
            led_period_next = fast_blink_ms;
            band_next       = BAND_LOW;
          end else begin
            charging_next = 1'b0;
            led_mode_next = LED_SET_ON;
            band_next     = BAND_MID;
          end
        end
      end
      KIND_RESTART: history_ready_next = 1'b0;
      default: ; // unused kind changes nothing
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history_ready <= 1'b0;
      charging      <= 1'b1;
      led_mode      <= LED_TIMED_START;
      led_elapsed   <= '0;
      led_period    <= '0;
      led_pin       <= 1'b0;
    end else if (advance) begin
      history_ready <= history_ready_next;
      charging      <= charging_next;
      led_mode      <= led_mode_next;
      led_elapsed   <= led_elapsed_next;
      led_period    <= led_period_next;
      led_pin       <= led_pin_next;
    end
  end

  // History shift line: entry 0 is newest
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        history[i] <= '0;
      end
    end else if (advance && fill_all) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        history[i] <= in_cap;
      end
    end else if (advance && shift_in) begin
      history[0] <= in_cap;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        history[i] <= history[i-1];
      end
    end
  end

  // The history entries after this beat, as seen by the result register
  logic [CAP_W-1:0] newest_next;
  logic [CAP_W-1:0] oldest_next;

  assign newest_next = (fill_all || shift_in) ? in_cap : history[0];
  assign oldest_next = fill_all ? in_cap :
                       shift_in ? history[HISTORY_DEPTH-2] : history[HISTORY_DEPTH-1];

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic               out_led;
  logic               out_charge;
  band_t              out_band;
  logic [VIB_W-1:0]   out_vib;
  logic [CAP_W-1:0]   out_newest;
  logic [CAP_W-1:0]   out_oldest;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_led    <= led_pin_next;
      out_charge <= charging_next;
      out_band   <= band_next;
      out_vib    <= vib_next;
      out_newest <= newest_next;
      out_oldest <= oldest_next;
    end
  end

  assign m_axis_tdata = {7'd0, out_oldest, out_newest, out_vib, out_charge, out_led};
  assign m_axis_tuser = out_band;

`ifndef SYNTHESIS
  // strong vibration only in the high band
  a_vib_band: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((out_band == BAND_HIGH) == (out_vib == VIB_STRONG)))
    else $error("vibration strength does not match band");

  // low band turns the charger on, high and middle turn it off
  a_charge_band: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_band != BAND_NONE) |-> (out_charge == (out_band == BAND_LOW)))
    else $error("charger enable does not match band");

  // history is marked unfilled only by a restart beat or by reset
  a_restart: assert property (@(posedge clk) disable iff (rst)
    $fell(history_ready) |-> ($past(rst) || ($past(advance) && $past(in_kind) == KIND_RESTART)))
    else $error("history flag cleared without restart");

  // a decided band always reports the newest entry as the sample just taken
  a_newest: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_band != BAND_NONE) |-> (out_newest == history[0]))
    else $error("newest capacity disagrees with history");
`endif

endmodule

`default_nettype wire

// ===== sim/charge_band_checker.sv =====
`default_nettype none

module charge_band_checker
  import cbl_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  input  wire logic                 s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,
  input  wire logic [2:0]           s_axis_tuser,
  input  wire logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  input  wire logic [31:0]          m_axis_tdata,
  input  wire logic [1:0]           m_axis_tuser,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  output int                        fails,
  output int                        pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               led;
    logic               chg;
    band_t              band;
    logic [VIB_W-1:0]   vib;
    logic [CAP_W-1:0]   newest;
    logic [CAP_W-1:0]   oldest;
  } ctrl_status_t;

  // settings mirror
  logic [CAP_W-1:0]   lo_th, hi_th;
  logic [STEP_W-1:0]  step_ms;
  logic [TIMER_W-1:0] on_ms, slow_ms, fast_ms;

  // controller state mirror
  logic [CAP_W-1:0]   hist [HISTORY_DEPTH];
  logic               hist_full;
  logic               charging;
  led_mode_t          mode;
  logic [TIMER_W-1:0] elapsed, period;
  logic               pin;

  ctrl_status_t status_due[$];

  initial begin
    fails   = 0;
    pending = 0;
  end

  function automatic void led_tick();
    unique case (mode)
      LED_SET_OFF: begin
        pin  = 1'b0;
        mode = LED_IDLE;
      end
      LED_SET_ON: begin
        pin  = 1'b1;
        mode = LED_IDLE;
      end
      LED_TIMED_START: begin
        pin     = 1'b1;
        elapsed = '0;
        period  = on_ms;
        mode    = LED_TIMED_WAIT;
      end
      LED_TIMED_WAIT: begin
        elapsed = elapsed + TIMER_W'(step_ms);
        if (elapsed >= period) begin
          pin  = 1'b0;
          mode = LED_IDLE;
        end
      end
      LED_BLINK: begin
        elapsed = elapsed + TIMER_W'(step_ms);
        if (elapsed >= period) begin
          elapsed = '0;
          pin     = ~pin;
        end
      end
      default: ;
    endcase
  endfunction

  // Apply one input beat to the mirrored state and return the status it leaves.
  function automatic ctrl_status_t advance_controller(kind_t kind, logic ok,
                                                      logic [CAP_W-1:0] cap);
    ctrl_status_t st;
    st.band = BAND_NONE;
    st.vib  = VIB_NONE;
    unique case (kind)
      KIND_TICK: led_tick();
      KIND_SAMPLE: begin
        if (ok) begin
          if (!hist_full) begin
            hist_full = 1'b1;
            for (int i = 0; i < HISTORY_DEPTH; i++) hist[i] = cap;
          end else if (hist[0] != cap) begin
            for (int i = HISTORY_DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
            hist[0] = cap;
          end
          // high test first, so crossed thresholds still pick a band
          if (hist[0] > hi_th) begin
            charging = 1'b0;
            mode     = LED_BLINK;
            period   = slow_ms;
            st.band  = BAND_HIGH;
            st.vib   = VIB_STRONG;
          end else if (hist[0] < lo_th) begin
            charging = 1'b1;
            mode     = LED_BLINK;
            period   = fast_ms;
            st.band  = BAND_LOW;
          end else begin
            charging = 1'b0;
            mode     = LED_SET_ON;
            st.band  = BAND_MID;
          end
        end
      end
      KIND_RESTART: hist_full = 1'b0;
      default: ;
    endcase
    st.led    = pin;
    st.chg    = charging;
    st.newest = hist[0];
    st.oldest = hist[HISTORY_DEPTH-1];
    return st;
  endfunction

  function automatic int field_bad(string field, int unsigned want, int unsigned got);
    if (want == got) return 0;
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    ctrl_status_t want;
    int bad;
    if (rst) begin
      lo_th     = LOW_THRESHOLD_RST;
      hi_th     = HIGH_THRESHOLD_RST;
      step_ms   = TICK_STEP_MS_RST;
      on_ms     = STARTUP_ON_MS_RST;
      slow_ms   = SLOW_BLINK_MS_RST;
      fast_ms   = FAST_BLINK_MS_RST;
      for (int i = 0; i < HISTORY_DEPTH; i++) hist[i] = '0;
      hist_full = 1'b0;
      charging  = 1'b1;
      mode      = LED_TIMED_START;
      elapsed   = '0;
      period    = '0;
      pin       = 1'b0;
      status_due.delete();
      pending  <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_LOW_THRESHOLD:  lo_th   = cfg_data[CAP_W-1:0];
          REG_HIGH_THRESHOLD: hi_th   = cfg_data[CAP_W-1:0];
          REG_TICK_STEP_MS:   step_ms = cfg_data[STEP_W-1:0];
          REG_STARTUP_ON_MS:  on_ms   = cfg_data;
          REG_SLOW_BLINK_MS:  slow_ms = cfg_data;
          REG_FAST_BLINK_MS:  fast_ms = cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, got tdata %h tuser %h",
                   $time, m_axis_tdata, m_axis_tuser);
          fails++;
        end else begin
          want = status_due.pop_front();
          bad  = field_bad("led_level", want.led, m_axis_tdata[0])
               + field_bad("charge_enable", want.chg, m_axis_tdata[1])
               + field_bad("vibrate_strength", want.vib, m_axis_tdata[8:2])
               + field_bad("newest_capacity", want.newest, m_axis_tdata[16:9])
               + field_bad("oldest_capacity", want.oldest, m_axis_tdata[24:17])
               + field_bad("tdata padding", 0, m_axis_tdata[31:25])
               + field_bad("band", want.band, m_axis_tuser);
          if (bad != 0) fails++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        status_due.push_back(advance_controller(kind_t'(s_axis_tuser[1:0]),
                                                s_axis_tuser[2], s_axis_tdata));
      pending <= status_due.size();
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_charge_band_led_controller.sv =====
`default_nettype none

module tb_charge_band_led_controller;

  timeunit 1ns;
  timeprecision 1ps;

  import cbl_pkg::*;

  localparam int GAP_MAX         = 18;    // longest idle stretch per beat, either side
  localparam int HOLD_CYCLES     = 120;   // long receiver hold-off, fills the pipeline
  localparam int HOLD_ITEMS      = 40;    // beats offered back to back during the hold
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 173;
  localparam int IDLE_RUN        = 25;    // beats between redraws of the idling mode
  localparam int SETTLE_CYCLES   = 4;     // two-stage pipeline plus margin
  localparam longint TIMEOUT_NS  = 64'd5_000_000;

  // spare register indexes, not in the map
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;   // [7:0] capacity
  logic [2:0]           s_axis_tuser = '0;   // [1:0] kind, [2] sample_ok
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;        // [0] led, [1] charge, [8:2] vib, [16:9] newest,
                                             // [24:17] oldest, [31:25] zero
  logic [1:0]           m_axis_tuser;        // [1:0] band
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int fails;
  int pending;

  // Stimulus shaping state; the checker keeps its own copy of the settings.
  bit               in_idle  = 1'b1;
  bit               out_idle = 1'b1;
  bit               hold_req = 1'b0;
  logic [CAP_W-1:0] cur_lo   = LOW_THRESHOLD_RST;
  logic [CAP_W-1:0] cur_hi   = HIGH_THRESHOLD_RST;
  logic [CAP_W-1:0] last_cap = '0;

  always #5 clk = ~clk;

  charge_band_led_controller dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  charge_band_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fails         (fails),
    .pending       (pending)
  );

  // Offer one input beat and return at the edge that takes it. Valid stays high
  // into the next call; drop it only when a gap is drawn, so it never gets two
  // updates in one step.
  task automatic send_item(kind_t kind, logic ok, logic [CAP_W-1:0] cap);
    int gap;
    gap = in_idle ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {ok, kind};
    s_axis_tdata  <= cap;
    if (kind == KIND_SAMPLE && ok) last_cap = cap;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Hold the input quiet until every expected beat is back, then let the pipeline settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write of a group.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Program every register; the 8-bit ones get random upper bits that must be dropped.
  task automatic apply_settings(logic [7:0] lo, logic [7:0] hi, logic [7:0] step,
                                logic [15:0] on_ms, logic [15:0] slow, logic [15:0] fast);
    write_reg(REG_LOW_THRESHOLD,  {8'($urandom_range(0, 255)), lo});
    write_reg(REG_HIGH_THRESHOLD, {8'($urandom_range(0, 255)), hi});
    write_reg(REG_TICK_STEP_MS,   {8'($urandom_range(0, 255)), step});
    write_reg(REG_STARTUP_ON_MS,  on_ms);
    write_reg(REG_SLOW_BLINK_MS,  slow);
    write_reg(REG_FAST_BLINK_MS,  fast);
    cfg_valid <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
  endtask

  // Favor repeats (no history shift) and values around the thresholds.
  function automatic logic [CAP_W-1:0] pick_capacity();
    int r;
    logic [CAP_W-1:0] base;
    r = $urandom_range(0, 99);
    if (r < 30) return last_cap;
    if (r < 60) begin
      base = $urandom_range(0, 1) ? cur_lo : cur_hi;
      return base + CAP_W'($urandom_range(0, 4)) - CAP_W'(2);
    end
    return CAP_W'($urandom_range(0, 255));
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      send_item(KIND_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    else if (r < 80)
      send_item(KIND_SAMPLE, 1'b1, pick_capacity());
    else if (r < 88)
      send_item(KIND_SAMPLE, 1'b0, 8'($urandom_range(0, 255)));
    else if (r < 95)
      send_item(KIND_RESTART, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    else
      send_item(KIND_UNUSED, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  // Result side: random stalls per beat, plus one long hold-off on request.
  initial begin : result_sink
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end else begin
        stall = out_idle ? $urandom_range(0, GAP_MAX) : 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Zero on-time so the startup flash ends on its first wait tick; spare
    // indexes must leave every setting alone.
    write_reg(REG_STARTUP_ON_MS, 16'd0);
    write_reg(REG_SPARE_6, 16'hFFFF);
    write_reg(REG_SPARE_7, 16'h5A5A);
    cfg_valid <= 1'b0;

    // Directed: unused kind before anything, startup flash, ignored sample,
    // history fill and hold, blink toggles, each band edge, refill after restart.
    send_item(KIND_UNUSED, 1'b1, 8'hFF);
    repeat (3) send_item(KIND_TICK, 1'b0, 8'h00);
    send_item(KIND_SAMPLE, 1'b0, 8'hFF);
    send_item(KIND_RESTART, 1'b0, 8'h00);
    send_item(KIND_SAMPLE, 1'b1, 8'd0);
    send_item(KIND_SAMPLE, 1'b1, 8'd0);
    repeat (7) send_item(KIND_TICK, 1'b1, 8'hFF);
    send_item(KIND_SAMPLE, 1'b1, 8'd255);
    send_item(KIND_SAMPLE, 1'b1, 8'd75);
    send_item(KIND_SAMPLE, 1'b1, 8'd76);
    send_item(KIND_SAMPLE, 1'b1, 8'd50);
    send_item(KIND_SAMPLE, 1'b1, 8'd49);
    send_item(KIND_RESTART, 1'b1, 8'hAA);
    send_item(KIND_SAMPLE, 1'b1, 8'd128);
    send_item(KIND_TICK, 1'b0, 8'h55);
    send_item(KIND_SAMPLE, 1'b0, 8'd200);

    for (int p = 0; p < PHASES; p++) begin
      // Pause until the block is idle before touching any register.
      drain();
      unique case (p)
        0: apply_settings(LOW_THRESHOLD_RST, HIGH_THRESHOLD_RST, TICK_STEP_MS_RST,
                          STARTUP_ON_MS_RST, SLOW_BLINK_MS_RST, FAST_BLINK_MS_RST);
        // top of every range: every sample lands in the middle band
        1: apply_settings(8'd0, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // crossed thresholds with the smallest nonzero step and blink periods
        2: apply_settings(8'd255, 8'd0, 8'd1, 16'd0, 16'd1, 16'd1);
        // zero half-periods toggle on every tick
        3: apply_settings(8'd128, 8'd128, 8'd7, 16'd0, 16'd0, 16'd0);
        default: apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(1, 255)), 16'($urandom_range(0, 65535)),
                                $urandom_range(0, 1) ? 16'($urandom_range(1, 400))
                                                     : 16'($urandom_range(1, 65535)),
                                $urandom_range(0, 1) ? 16'($urandom_range(1, 400))
                                                     : 16'($urandom_range(1, 65535)));
      endcase

      if (p == 4) begin
        // Ask the sink for a long hold-off and keep offering beats back to back
        // so the pipeline fills and input ready drops.
        hold_req = 1'b1;
        in_idle  = 1'b0;
        repeat (HOLD_ITEMS) random_item();
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % IDLE_RUN == 0) begin
          in_idle  = $urandom_range(0, 3) != 0;
          out_idle = $urandom_range(0, 3) != 0;
        end
        random_item();
      end
    end

    drain();
    if (fails == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/cbl_pkg.sv
rtl/charge_band_led_controller.sv
sim/charge_band_checker.sv
sim/tb_charge_band_led_controller.sv
